@@ src/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// shs_pkg
// Shared types, command codes and SHA-256 constants for the stream hasher.
// ----------------------------------------------------------------------------
package shs_pkg;

   // command codes of an input word
   localparam logic CMD_APPEND = 1'b0;
   localparam logic CMD_FINISH = 1'b1;

   localparam int BLOCK_BITS = 512;
   localparam int LEN_POS    = 56;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // one padded or full message block handed from front to back
   typedef struct packed {
      logic [BLOCK_BITS-1:0] block;
      logic                  final_blk;
   } blk_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_ADD,
      ST_EMIT
   } back_state_type;

   function automatic logic [31:0] init_h(input logic [2:0] i);
      logic [31:0] r;
      unique case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         3'd7: r = 32'h5be0cd19;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] r;
      unique case (i)
         6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; 6'd63: r = 32'hc67178f2;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

@@ src/shs_front.sv @@
// ----------------------------------------------------------------------------
// shs_front
// Gathers message bytes into a block, pads on finish and queues blocks.
// ----------------------------------------------------------------------------
module shs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  shs_pkg::req_type req_payload,
   output logic             push,
   output shs_pkg::blk_type push_data,
   input  logic             q_full
);
   import shs_pkg::*;

   logic [5:0]            fill_ff, fill_in;
   logic [60:0]           total_ff, total_in;
   logic [BLOCK_BITS-1:0] buf_ff, buf_in;
   logic                  pend_ff, pend_in;
   logic [63:0]           len_ff, len_in;
   logic                  accept;
   logic [63:0]           len_now;
   logic [BLOCK_BITS-1:0] pad_blk;

   assign req_ready = !pend_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign len_now   = {total_ff, 3'b000};

   // build the padded block: keep data below fill, marker at fill, zeros above
   always_comb begin
      for (int k = 0; k < 64; k++) begin
         if (6'(k) < fill_ff) begin
            pad_blk[BLOCK_BITS-1-8*k -: 8] = buf_ff[BLOCK_BITS-1-8*k -: 8];
         end else if (6'(k) == fill_ff) begin
            pad_blk[BLOCK_BITS-1-8*k -: 8] = 8'h80;
         end else begin
            pad_blk[BLOCK_BITS-1-8*k -: 8] = 8'h00;
         end
      end
   end

   // classify the word and hand blocks to the queue
   always_comb begin
      fill_in   = fill_ff;
      total_in  = total_ff;
      buf_in    = buf_ff;
      pend_in   = pend_ff;
      len_in    = len_ff;
      push      = 1'b0;
      push_data = '{block: pad_blk, final_blk: 1'b0};
      if (pend_ff) begin
         if (!q_full) begin
            push      = 1'b1;
            push_data = '{block: {{(BLOCK_BITS-64){1'b0}}, len_ff}, final_blk: 1'b1};
            pend_in   = 1'b0;
         end
      end else if (accept) begin
         unique case (req_payload.cmd)
            CMD_APPEND: begin
               for (int k = 0; k < 64; k++) begin
                  if (6'(k) == fill_ff) begin
                     buf_in[BLOCK_BITS-1-8*k -: 8] = req_payload.data_byte;
                  end
               end
               fill_in  = fill_ff + 6'd1;
               total_in = total_ff + 61'd1;
               if (fill_ff == 6'd63) begin
                  push      = 1'b1;
                  push_data = '{block: buf_in, final_blk: 1'b0};
               end
            end
            CMD_FINISH: begin
               push     = 1'b1;
               fill_in  = '0;
               total_in = '0;
               if (fill_ff < 6'(LEN_POS)) begin
                  push_data = '{block: {pad_blk[BLOCK_BITS-1:64], len_now}, final_blk: 1'b1};
               end else begin
                  pend_in = 1'b1;
                  len_in  = len_now;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // hold control state and block data
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         total_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         total_ff <= total_in;
         pend_ff  <= pend_in;
      end
      buf_ff <= buf_in;
      len_ff <= len_in;
   end

endmodule

@@ src/shs_queue.sv @@
// ----------------------------------------------------------------------------
// shs_queue
// Two-entry block queue between the front and the compression engine.
// ----------------------------------------------------------------------------
module shs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  shs_pkg::blk_type push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output shs_pkg::blk_type pop_data
);
   import shs_pkg::*;

   blk_type    mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign pop_data  = mem_ff[rd_ptr_ff];

   // advance pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("block queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) !(pop && !not_empty))
      else $error("block queue underflow");
`endif

endmodule

@@ src/shs_back.sv @@
// ----------------------------------------------------------------------------
// shs_back
// 64-round compression engine, one round per cycle, and digest emission.
// ----------------------------------------------------------------------------
module shs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  shs_pkg::blk_type q_data,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output shs_pkg::rsp_type rsp_payload
);
   import shs_pkg::*;

   back_state_type state_ff, state_in;
   logic [31:0]    w_ff [16];
   logic [31:0]    v_ff [8];
   logic [31:0]    hash_ff [8];
   logic [5:0]     round_ff;
   logic [2:0]     idx_ff;
   logic           final_ff;
   logic           out_acc;
   logic [31:0]    t1, t2, w_next, s0, s1, e, a;

   assign out_acc = rsp_valid && rsp_ready;
   assign rsp_payload = '{digest_word: hash_ff[idx_ff], word_index: idx_ff,
                          last_word: idx_ff == 3'd7};

   // round function and schedule extension
   always_comb begin
      e  = v_ff[4];
      a  = v_ff[0];
      t1 = v_ff[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
         + ((e & v_ff[5]) ^ (~e & v_ff[6])) + round_k(round_ff) + w_ff[0];
      t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
         + ((a & v_ff[1]) ^ (a & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      s0 = {w_ff[1][6:0], w_ff[1][31:7]} ^ {w_ff[1][17:0], w_ff[1][31:18]}
         ^ (w_ff[1] >> 3);
      s1 = {w_ff[14][16:0], w_ff[14][31:17]} ^ {w_ff[14][18:0], w_ff[14][31:19]}
         ^ (w_ff[14] >> 10);
      w_next = w_ff[0] + s0 + w_ff[9] + s1;
   end

   // next state and queue pop
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      rsp_valid = state_ff == ST_EMIT;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            if (round_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            state_in = final_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_acc && idx_ff == 3'd7) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath: load block, run rounds, fold into hash, step digest words
   always_ff @(posedge clock) begin
      if (reset) begin
         round_ff <= '0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) begin
            hash_ff[i] <= init_h(3'(i));
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               round_ff <= '0;
               idx_ff   <= '0;
               if (q_valid) begin
                  final_ff <= q_data.final_blk;
                  for (int i = 0; i < 16; i++) begin
                     w_ff[i] <= q_data.block[BLOCK_BITS-1-32*i -: 32];
                  end
                  for (int i = 0; i < 8; i++) begin
                     v_ff[i] <= hash_ff[i];
                  end
               end
            end
            ST_ROUND: begin
               round_ff <= round_ff + 6'd1;
               for (int i = 0; i < 15; i++) begin
                  w_ff[i] <= w_ff[i+1];
               end
               w_ff[15] <= w_next;
               v_ff[0] <= t1 + t2;
               v_ff[1] <= v_ff[0];
               v_ff[2] <= v_ff[1];
               v_ff[3] <= v_ff[2];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[5] <= v_ff[4];
               v_ff[6] <= v_ff[5];
               v_ff[7] <= v_ff[6];
            end
            ST_ADD: begin
               for (int i = 0; i < 8; i++) begin
                  hash_ff[i] <= hash_ff[i] + v_ff[i];
               end
            end
            ST_EMIT: begin
               if (out_acc) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) begin
                        hash_ff[i] <= init_h(3'(i));
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

`ifndef NO_ASSERTIONS
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (out_acc && idx_ff == 3'd7) |=> (hash_ff[0] == init_h(3'd0) && idx_ff == 3'd0))
      else $error("hash not reinitialized after digest");
   a_round_start: assert property (@(posedge clock) disable iff (reset)
      pop |=> (round_ff == 6'd0 && state_ff == ST_ROUND))
      else $error("round count not cleared at block start");
`endif

endmodule

@@ src/sha256_stream_hasher_unit.sv @@
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Streaming SHA-256: byte words in, eight digest words out per message.
// ----------------------------------------------------------------------------
//   channel | direction | word contents
//   req_    | in        | cmd (append / finish), data_byte
//   rsp_    | out       | digest_word, word_index, last_word
//
// Append words are taken one per cycle while the two-block queue has room and no length block is pending.
// Each block passes through the compression engine as load, 64 rounds, add.
// Finish takes one or two queue slots; digest words leave one per rsp_ handshake.
// Synchronous active-high reset restores the initial hash and empties the queue.
// Stalls on rsp_ hold the engine; the front keeps filling until the queue is full.
module sha256_stream_hasher_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  shs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output shs_pkg::rsp_type rsp_payload
);
   import shs_pkg::*;

   logic    push, q_full, pop, q_valid;
   blk_type push_data, q_data;

   shs_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .push(push), .push_data(push_data), .q_full(q_full)
   );

   shs_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data), .full(q_full),
      .pop(pop), .not_empty(q_valid), .pop_data(q_data)
   );

   shs_back u_back (
      .clock(clock), .reset(reset),
      .q_valid(q_valid), .q_data(q_data), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

endmodule
